### rtl/core/multi_click_long_press_detector_top_macros.svh
// Assertion macros for the multi-click / long-press detector.
`ifndef MULTI_CLICK_LONG_PRESS_DETECTOR_TOP_MACROS_SVH
`define MULTI_CLICK_LONG_PRESS_DETECTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Clocked on clk, off while arst_n is low.
`define MCLPD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked on clk, checked during reset as well.
`define MCLPD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MCLPD_ASSERT(label, prop, msg)
`define MCLPD_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### rtl/core/mclpd_pkg.sv
// Shared types and constants for the multi-click / long-press detector.
`timescale 1ns / 1ps

package mclpd_pkg;

	localparam int NOW_W      = 32;
	localparam int CFG_W      = 16;
	localparam int PCNT_W     = 8;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam int TIME_BITS_DEF = 32;
	localparam int COUNT_MAX_DEF = 255;

	localparam logic [CFG_W-1:0] HOLDOFF_RST  = 16'd50;
	localparam logic [CFG_W-1:0] LONG_RST     = 16'd3000;
	localparam logic [CFG_W-1:0] SEQ_RST      = 16'd500;
	localparam logic [PCNT_W-1:0] PCNT_SAT    = 8'd255;

	typedef enum logic [1:0] {
		REG_HOLDOFF = 2'd0,
		REG_LONG    = 2'd1,
		REG_SEQ     = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [NOW_W-1:0] now_ms;
		logic             button_down;
	} in_beat_t;

	typedef struct packed {
		logic              is_long;
		logic [PCNT_W-1:0] press_count;
	} out_beat_t;

endpackage

### rtl/core/multi_click_long_press_detector_top.sv
// Top level of the multi-click / long-press button detector.
`timescale 1ns / 1ps
`include "multi_click_long_press_detector_top_macros.svh"

//  channel | dir | handshake           | beat
//  --------+-----+---------------------+------------------------------------
//  in      | in  | in_valid / in_stall | in_data: now_ms[31:0], button_down
//  out     | out | out_valid/out_stall | out_data: is_long, press_count[7:0]
//  cfg     | in  | APB psel/penable    | holdoff, long press, sequence timeout
//
// One sample beat per cycle sustained while the output is not stalled. A beat
// is held in the input register, is evaluated against the detector state in a
// single pass, and any event is registered in the output register. in_stall
// rises only when the input register holds a beat and the output register is
// full and stalled. Reset clears state and loads the register defaults; no
// clearing pass is needed.

module multi_click_long_press_detector_top #(
	parameter int TIME_BITS = mclpd_pkg::TIME_BITS_DEF,
	parameter int COUNT_MAX = mclpd_pkg::COUNT_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  mclpd_pkg::in_beat_t                 in_data,
	// event channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output mclpd_pkg::out_beat_t                out_data,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mclpd_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [mclpd_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [mclpd_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready
);

	localparam int CNT_W = $clog2(COUNT_MAX + 1);
	localparam int SAT_W = CNT_W + mclpd_pkg::PCNT_W;

	// ---------------- configuration registers ----------------
	logic [mclpd_pkg::CFG_W-1:0] cfg_holdoff_q;
	logic [mclpd_pkg::CFG_W-1:0] cfg_long_q;
	logic [mclpd_pkg::CFG_W-1:0] cfg_seq_q;
	logic                        cfg_wr;
	mclpd_pkg::reg_idx_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = mclpd_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_holdoff_q <= mclpd_pkg::HOLDOFF_RST;
			cfg_long_q    <= mclpd_pkg::LONG_RST;
			cfg_seq_q     <= mclpd_pkg::SEQ_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				mclpd_pkg::REG_HOLDOFF: cfg_holdoff_q <= pwdata[mclpd_pkg::CFG_W-1:0];
				mclpd_pkg::REG_LONG:    cfg_long_q    <= pwdata[mclpd_pkg::CFG_W-1:0];
				mclpd_pkg::REG_SEQ:     cfg_seq_q     <= pwdata[mclpd_pkg::CFG_W-1:0];
				default: ;  // unmapped address: write dropped
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			mclpd_pkg::REG_HOLDOFF: prdata = mclpd_pkg::APB_DATA_W'(cfg_holdoff_q);
			mclpd_pkg::REG_LONG:    prdata = mclpd_pkg::APB_DATA_W'(cfg_long_q);
			mclpd_pkg::REG_SEQ:     prdata = mclpd_pkg::APB_DATA_W'(cfg_seq_q);
			default:                prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	logic                 valid_s1;
	mclpd_pkg::in_beat_t  beat_s1;
	logic                 out_valid_q;
	mclpd_pkg::out_beat_t out_q;
	logic                 out_free;
	logic                 adv;

	// Output slot is free when empty or being drained this edge.
	assign out_free = ~out_valid_q | ~out_stall;
	assign adv      = valid_s1 & out_free;
	assign in_stall = valid_s1 & ~out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			beat_s1 <= in_data;
		end
	end

	// ---------------- detector state ----------------
	logic                 prev_level_q;
	logic                 armed_q;
	logic                 long_rep_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] holdoff_q;
	logic [CNT_W-1:0]     count_q;

	// ---------------- single-pass evaluation ----------------
	logic [TIME_BITS+mclpd_pkg::NOW_W-1:0] now_wide;
	logic [TIME_BITS-1:0] now_t;
	logic                 level;
	logic                 skip;
	logic                 rise;
	logic [TIME_BITS-1:0] start_n;
	logic                 armed_r;
	logic                 long_rep_r;
	logic [TIME_BITS-1:0] elapsed;
	logic                 long_ev;
	logic                 fall;
	logic [CNT_W-1:0]     count_f;
	logic                 armed_f;
	logic [TIME_BITS-1:0] holdoff_f;
	logic                 short_ev;
	logic [CNT_W-1:0]     count_ev;
	logic [SAT_W-1:0]     count_ext;
	logic [mclpd_pkg::PCNT_W-1:0] count_sat;

	// Timestamp taken modulo 2^TIME_BITS (zero-extended if wider).
	assign now_wide = {{TIME_BITS{1'b0}}, beat_s1.now_ms};
	assign now_t    = now_wide[TIME_BITS-1:0];
	assign level    = beat_s1.button_down;

	// Release hold-off: plain unsigned compare, wrapped deadline never blocks.
	assign skip = now_t < holdoff_q;

	// Press start
	assign rise       = level & ~prev_level_q;
	assign start_n    = rise ? now_t : start_q;
	assign armed_r    = rise | armed_q;
	assign long_rep_r = ~rise & long_rep_q;

	assign elapsed = now_t - start_n;

	assign long_ev = level & (elapsed > TIME_BITS'(cfg_long_q)) & ~long_rep_r;

	// Release of an armed press: count it unless it was already a long press.
	assign fall      = ~level & prev_level_q & armed_r;
	assign count_f   = (fall && !long_rep_r && (count_q < CNT_W'(COUNT_MAX)))
		? count_q + CNT_W'(1) : count_q;
	assign armed_f   = armed_r & ~fall;
	assign holdoff_f = fall ? now_t + TIME_BITS'(cfg_holdoff_q) : holdoff_q;

	// Quiet gap after clicks ends the sequence.
	assign short_ev = ~long_ev & (elapsed > TIME_BITS'(cfg_seq_q)) & (count_f != '0)
		& ~level & ~long_rep_r;

	// Long event reports the count before this sample's release logic.
	assign count_ev  = long_ev ? count_q : count_f;
	assign count_ext = {{mclpd_pkg::PCNT_W{1'b0}}, count_ev};
	assign count_sat = (count_ext > SAT_W'(mclpd_pkg::PCNT_SAT))
		? mclpd_pkg::PCNT_SAT : count_ext[mclpd_pkg::PCNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			armed_q      <= 1'b0;
			long_rep_q   <= 1'b0;
			start_q      <= '0;
			holdoff_q    <= '0;
			count_q      <= '0;
		end else if (adv && !skip) begin
			start_q <= start_n;
			if (long_ev) begin
				// prev level kept on event beats
				armed_q    <= armed_r;
				long_rep_q <= 1'b1;
				count_q    <= '0;
			end else begin
				armed_q    <= armed_f;
				long_rep_q <= long_rep_r;
				holdoff_q  <= holdoff_f;
				count_q    <= short_ev ? '0 : count_f;
				if (!short_ev) begin
					prev_level_q <= level;
				end
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv & ~skip & (long_ev | short_ev);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.is_long     <= long_ev;
			out_q.press_count <= count_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- assertions ----------------
	`MCLPD_ASSERT(a_s1_hold, (valid_s1 && !out_free) |=> (valid_s1 && $stable(beat_s1)), "blocked sample left the input register")
	`MCLPD_ASSERT(a_long_flag, (adv && !skip && long_ev) |=> long_rep_q, "long press not marked as reported")
	`MCLPD_ASSERT(a_count_clear, (adv && !skip && (long_ev || short_ev)) |=> (count_q == '0), "click count not cleared after event")
	`MCLPD_ASSERT(a_holdoff_quiet, (adv && skip) |=> ($stable(count_q) && $stable(prev_level_q) && $stable(start_q)), "state moved during hold-off")
	`MCLPD_ASSERT(a_out_source, $rose(out_valid_q) |-> $past(adv), "event without a sample")
	`MCLPD_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(COUNT_MAX), "click count above its limit")

endmodule
